[src/maze_dfs_backtracker_macros.svh]
// Assertion macros for the maze carver checker.
`ifndef MAZE_DFS_BACKTRACKER_MACROS_SVH
`define MAZE_DFS_BACKTRACKER_MACROS_SVH

// Clocked check, masked while reset is high.
`define MDB_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("maze_dfs_backtracker: check failed");

// Clocked check that also holds through reset.
`define MDB_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("maze_dfs_backtracker: reset check failed");

`endif

[src/mdb_pkg.sv]
`timescale 1ns / 1ps
package mdb_pkg;

   localparam int FIELD_W    = 4;
   localparam int ORDER_W    = 8;
   localparam int TRIED_W    = 3;
   localparam int SZ_W       = 8;
   localparam int CFG_W      = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 24;

   localparam logic [CFG_W-1:0]     SIZE_RESET = 5'd10;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS   = 1'b1;
   localparam logic [TRIED_W-1:0]   TRIED_ALL  = 3'd4;

   typedef enum logic [1:0] {
      DIR_UP    = 2'd0,
      DIR_RIGHT = 2'd1,
      DIR_DOWN  = 2'd2,
      DIR_LEFT  = 2'd3
   } dir_type;

   typedef struct packed {
      logic clr_step;
      logic accept;
      logic try_step;
      logic pop;
      logic load_top;
      logic emit_pass;
      logic emit_done;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic depth_zero;
      logic depth_one;
      logic top_exhausted;
      logic try_ok;
      logic nbr_visited;
      logic out_free;
   } stat_type;

endpackage

[src/mdb_ram.sv]
`timescale 1ns / 1ps
module mdb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[src/mdb_ctrl.sv]
`timescale 1ns / 1ps
module mdb_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  mdb_pkg::stat_type stat,
   output mdb_pkg::cmd_type  cmd
);
   import mdb_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_TRY,
      ST_LOAD,
      ST_CHECK
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid && ready_ff) begin
               cmd.accept = 1'b1;
               state_in   = ST_TRY;
            end
         end
         ST_TRY: begin
            if (stat.depth_zero) begin
               if (stat.out_free) begin
                  cmd.emit_done = 1'b1;
                  state_in      = ST_CLEAR;
               end
            end else if (stat.top_exhausted) begin
               cmd.pop  = 1'b1;
               state_in = stat.depth_one ? ST_TRY : ST_LOAD;
            end else begin
               cmd.try_step = 1'b1;
               if (stat.try_ok) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_LOAD: begin
            cmd.load_top = 1'b1;
            state_in     = ST_TRY;
         end
         ST_CHECK: begin
            if (stat.nbr_visited) begin
               state_in = ST_TRY;
            end else if (stat.out_free) begin
               cmd.emit_pass = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == ST_IDLE);
      end
   end

   assign req_tready = ready_ff;

endmodule

[src/mdb_dp.sv]
`timescale 1ns / 1ps
module mdb_dp #(
   parameter int MAX_ROWS = 16,
   parameter int MAX_COLS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  mdb_pkg::cmd_type                   cmd,
   output mdb_pkg::stat_type                  stat,
   input  logic [mdb_pkg::CFG_W-1:0]          rows_cfg,
   input  logic [mdb_pkg::CFG_W-1:0]          cols_cfg,
   input  logic [mdb_pkg::ORDER_W-1:0]        req_order,
   input  logic                               rsp_tready,
   output logic                               rsp_tvalid,
   output logic [mdb_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                               rsp_tuser
);
   import mdb_pkg::*;

   localparam int RW      = $clog2(MAX_ROWS);
   localparam int CW      = $clog2(MAX_COLS);
   localparam int CELLS   = MAX_ROWS * MAX_COLS;
   localparam int AW      = $clog2(CELLS);
   localparam int DEPTH_W = $clog2(CELLS + 1);
   localparam int FRAME_W = RW + CW + ORDER_W + TRIED_W;

   function automatic logic [SZ_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                  input logic [SZ_W-1:0] most);
      logic [SZ_W-1:0] w;
      w = SZ_W'(v);
      if (w == '0) begin
         return SZ_W'(1);
      end
      if (w > most) begin
         return most;
      end
      return w;
   endfunction

   function automatic logic [AW-1:0] cell_idx(input logic [RW-1:0] r,
                                              input logic [CW-1:0] c);
      return AW'(AW'(r) * AW'(MAX_COLS)) + AW'(c);
   endfunction

   // top of stack lives in flops; RAM holds the frames below it
   logic [RW-1:0]      top_row_ff;
   logic [CW-1:0]      top_col_ff;
   logic [ORDER_W-1:0] top_order_ff;
   logic [TRIED_W-1:0] top_tried_ff;
   logic [DEPTH_W-1:0] depth_ff;
   logic [RW-1:0]      pend_row_ff;
   logic [CW-1:0]      pend_col_ff;
   logic [AW-1:0]      clr_addr_ff;
   logic [RW-1:0]      nbr_row_ff;
   logic [CW-1:0]      nbr_col_ff;
   dir_type            nbr_dir_ff;
   logic               rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic               rsp_done_ff;

   logic [SZ_W-1:0]    eff_rows, eff_cols;
   logic [SZ_W-1:0]    row_x, col_x, nr_x, nc_x;
   logic [ORDER_W-1:0] order_shift;
   dir_type            try_dir;
   logic               try_ok;
   logic [RW-1:0]      nbr_row;
   logic [CW-1:0]      nbr_col;
   logic [AW-1:0]      nbr_idx, pend_idx;

   logic [DEPTH_W-1:0] depth_m1, depth_m2;
   logic               push_ok;
   logic               vis_we;
   logic [AW-1:0]      vis_waddr;
   logic [0:0]         vis_wdata, vis_rdata;
   logic               stk_we;
   logic [FRAME_W-1:0] stk_wdata, stk_rdata;

   logic [SZ_W-1:0]    from_row_x, from_col_x, to_row_x, to_col_x;

   assign eff_rows = clamp_size(rows_cfg, SZ_W'(MAX_ROWS));
   assign eff_cols = clamp_size(cols_cfg, SZ_W'(MAX_COLS));

   // neighbor of the top cell in its next untried direction
   always_comb begin
      order_shift = top_order_ff >> {top_tried_ff[1:0], 1'b0};
      try_dir     = dir_type'(order_shift[1:0]);
      row_x       = SZ_W'(top_row_ff);
      col_x       = SZ_W'(top_col_ff);
      nr_x        = row_x;
      nc_x        = col_x;
      try_ok      = 1'b0;
      case (try_dir)
         DIR_UP: begin
            try_ok = (row_x != '0);
            nr_x   = row_x - SZ_W'(1);
         end
         DIR_RIGHT: begin
            try_ok = ((col_x + SZ_W'(1)) < eff_cols);
            nc_x   = col_x + SZ_W'(1);
         end
         DIR_DOWN: begin
            try_ok = ((row_x + SZ_W'(1)) < eff_rows);
            nr_x   = row_x + SZ_W'(1);
         end
         DIR_LEFT: begin
            try_ok = (col_x != '0);
            nc_x   = col_x - SZ_W'(1);
         end
         default: begin
            try_ok = 1'b0;
         end
      endcase
   end

   assign nbr_row  = nr_x[RW-1:0];
   assign nbr_col  = nc_x[CW-1:0];
   assign nbr_idx  = cell_idx(nbr_row, nbr_col);
   assign pend_idx = cell_idx(pend_row_ff, pend_col_ff);

   // visited map: cleared by sweep, set on entry
   assign vis_we    = cmd.clr_step | cmd.accept;
   assign vis_waddr = cmd.clr_step ? clr_addr_ff : pend_idx;
   assign vis_wdata = cmd.accept;

   mdb_ram #(
      .WIDTH (1),
      .DEPTH (CELLS)
   ) u_visited (
      .clock (clock),
      .we    (vis_we),
      .waddr (vis_waddr),
      .wdata (vis_wdata),
      .re    (cmd.try_step),
      .raddr (nbr_idx),
      .rdata (vis_rdata)
   );

   // walk stack: old top spills to RAM on push, refills on pop
   assign depth_m1  = depth_ff - DEPTH_W'(1);
   assign depth_m2  = depth_ff - DEPTH_W'(2);
   assign push_ok   = (depth_ff != DEPTH_W'(CELLS));
   assign stk_we    = cmd.accept && push_ok && (depth_ff != '0);
   assign stk_wdata = {top_row_ff, top_col_ff, top_order_ff, top_tried_ff};

   mdb_ram #(
      .WIDTH (FRAME_W),
      .DEPTH (CELLS)
   ) u_stack (
      .clock (clock),
      .we    (stk_we),
      .waddr (depth_m1[AW-1:0]),
      .wdata (stk_wdata),
      .re    (cmd.pop),
      .raddr (depth_m2[AW-1:0]),
      .rdata (stk_rdata)
   );

   assign from_row_x = SZ_W'(top_row_ff);
   assign from_col_x = SZ_W'(top_col_ff);
   assign to_row_x   = SZ_W'(nbr_row_ff);
   assign to_col_x   = SZ_W'(nbr_col_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff     <= '0;
         pend_row_ff  <= '0;
         pend_col_ff  <= '0;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clr_step) begin
            clr_addr_ff <= stat.clear_last ? '0 : clr_addr_ff + AW'(1);
         end
         if (cmd.accept && push_ok) begin
            depth_ff     <= depth_ff + DEPTH_W'(1);
            top_row_ff   <= pend_row_ff;
            top_col_ff   <= pend_col_ff;
            top_order_ff <= req_order;
            top_tried_ff <= '0;
         end
         if (cmd.pop) begin
            depth_ff <= depth_m1;
         end
         if (cmd.load_top) begin
            {top_row_ff, top_col_ff, top_order_ff, top_tried_ff} <= stk_rdata;
         end
         if (cmd.try_step) begin
            top_tried_ff <= top_tried_ff + TRIED_W'(1);
            nbr_row_ff   <= nbr_row;
            nbr_col_ff   <= nbr_col;
            nbr_dir_ff   <= try_dir;
         end
         if (cmd.emit_pass) begin
            pend_row_ff  <= nbr_row_ff;
            pend_col_ff  <= nbr_col_ff;
            rsp_data_ff  <= {6'b0, to_col_x[FIELD_W-1:0], to_row_x[FIELD_W-1:0],
                             nbr_dir_ff, from_col_x[FIELD_W-1:0],
                             from_row_x[FIELD_W-1:0]};
            rsp_done_ff  <= 1'b0;
            rsp_valid_ff <= 1'b1;
         end else if (cmd.emit_done) begin
            pend_row_ff  <= '0;
            pend_col_ff  <= '0;
            clr_addr_ff  <= '0;
            rsp_data_ff  <= '0;
            rsp_done_ff  <= 1'b1;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      stat               = '0;
      stat.clear_last    = (clr_addr_ff == AW'(CELLS - 1));
      stat.depth_zero    = (depth_ff == '0);
      stat.depth_one     = (depth_ff == DEPTH_W'(1));
      stat.top_exhausted = (top_tried_ff == TRIED_ALL);
      stat.try_ok        = try_ok;
      stat.nbr_visited   = vis_rdata[0];
      stat.out_free      = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_done_ff;

endmodule

[src/maze_dfs_backtracker.sv]
// A passage is emitted once its item is taken and the walk has found an unvisited
//   in-bounds neighbor, skipping out-of-bounds tries and visited cells and popping
//   exhausted tops off the stack. Items are taken one at a time; the visited map
//   has a single read port and the stack walk moves one frame at a time.
// Reset (synchronous, active high) and each done result start a clearing pass over
//   all MAX_ROWS*MAX_COLS cells of the visited map; req_tready stays low meanwhile.
`timescale 1ns / 1ps
module maze_dfs_backtracker #(
   parameter int MAX_ROWS = 16,
   parameter int MAX_COLS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   // request items
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [mdb_pkg::REQ_DATA_W-1:0]     req_tdata,   // [7:0] direction_order
   // result items
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [3:0] from_row, [7:4] from_col, [9:8] carve_dir, [13:10] to_row,
   // [17:14] to_col, [23:18] zero
   output logic [mdb_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                               rsp_tuser,   // [0] done_res
   // configuration writes
   input  logic                               csr_we,
   input  logic [mdb_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mdb_pkg::CFG_W-1:0]          csr_wdata
);
   import mdb_pkg::*;

   // Size registers; clamping to 1..MAX happens where they are used.
   logic [CFG_W-1:0] rows_ff;
   logic [CFG_W-1:0] cols_ff;

   cmd_type  cmd;
   stat_type stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= SIZE_RESET;
         cols_ff <= SIZE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ROWS: rows_ff <= csr_wdata;
            CSR_COLS: cols_ff <= csr_wdata;
            default: begin
               rows_ff <= rows_ff;
            end
         endcase
      end
   end

   // Sequencer: clear sweep, accept, try/backtrack walk, emit.
   mdb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // Stack, visited map, neighbor logic and the result register.
   mdb_dp #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .rows_cfg   (rows_ff),
      .cols_cfg   (cols_ff),
      .req_order  (req_tdata[ORDER_W-1:0]),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

[src/mdb_checker.sv]
`timescale 1ns / 1ps
`include "maze_dfs_backtracker_macros.svh"
module mdb_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [mdb_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                            rsp_tuser
);
   import mdb_pkg::*;

   logic [FIELD_W-1:0] fr, fc, tr, tc;
   logic [1:0]         cd;
   logic               geo_ok;
   logic               done_zero;

   assign fr = rsp_tdata[3:0];
   assign fc = rsp_tdata[7:4];
   assign cd = rsp_tdata[9:8];
   assign tr = rsp_tdata[13:10];
   assign tc = rsp_tdata[17:14];

   // a passage always joins two adjacent cells in its direction
   always_comb begin
      case (dir_type'(cd))
         DIR_UP:    geo_ok = (tr + 4'd1 == fr) && (tc == fc);
         DIR_RIGHT: geo_ok = (fc + 4'd1 == tc) && (tr == fr);
         DIR_DOWN:  geo_ok = (fr + 4'd1 == tr) && (tc == fc);
         DIR_LEFT:  geo_ok = (tc + 4'd1 == fc) && (tr == fr);
         default:   geo_ok = 1'b0;
      endcase
   end

   assign done_zero = (rsp_tdata == '0);

   `MDB_ASSERT_ALWAYS(a_reset_quiet, clock, $past(reset) |-> !rsp_tvalid && !req_tready)
   `MDB_ASSERT(a_done_zero, clock, reset, rsp_tvalid && rsp_tuser |-> done_zero)
   `MDB_ASSERT(a_carve_adjacent, clock, reset, rsp_tvalid && !rsp_tuser |-> geo_ok)
   `MDB_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

endmodule

bind maze_dfs_backtracker mdb_checker u_mdb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
